// ===== rtl/cbwa_pkg.sv =====
// shared types and constants for the code-binned weighted accumulator
package cbwa_pkg;

    localparam int NUM_BINS_DEF = 16;
    localparam int CODE_W       = 8;
    localparam int NIB_W        = 4;
    localparam int VAL_W        = 16;
    localparam int PROD_W       = 2 * VAL_W;
    localparam int ACC_W        = 48;
    localparam int BIN_W        = 4;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic [CODE_W-1:0]       code_byte;
        logic signed [VAL_W-1:0] query_even;
        logic signed [VAL_W-1:0] query_odd;
        logic signed [VAL_W-1:0] step_even;
        logic signed [VAL_W-1:0] step_odd;
        logic                    odd_valid;
        logic                    final_item;
    } t_in_item;

    typedef struct packed {
        logic [BIN_W-1:0]        bin_index;
        logic signed [ACC_W-1:0] bin_sum;
        logic                    last_bin;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVEN = 4'b0010,
        S_ODD  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic add_even;
        logic add_odd;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic odd_valid;
        logic final_item;
        logic out_free;
        logic emit_last;
    } t_status;

endpackage

// ===== rtl/cbwa_ctrl.sv =====
// controller state machine for the code-binned weighted accumulator
module cbwa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  cbwa_pkg::t_status i_status,
    output cbwa_pkg::t_cmd   o_cmd
);
    import cbwa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVEN;
                end
            end
            S_EVEN: begin
                o_cmd.add_even = 1'b1;
                if (i_status.odd_valid) begin
                    n_state = S_ODD;
                end else if (i_status.final_item) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ODD: begin
                o_cmd.add_odd = 1'b1;
                n_state = i_status.final_item ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                // one bin per free output slot
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/cbwa_datapath.sv =====
// multipliers, bin accumulators with saturation, and output register
module cbwa_datapath #(
    parameter int NUM_BINS = cbwa_pkg::NUM_BINS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cbwa_pkg::t_in_item  i_in_item,
    input  cbwa_pkg::t_cmd      i_cmd,
    output cbwa_pkg::t_status   o_status,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cbwa_pkg::t_out_item o_out_item
);
    import cbwa_pkg::*;

    localparam int CNT_W = $clog2(NUM_BINS);

    logic signed [PROD_W-1:0] r_prod_even;
    logic signed [PROD_W-1:0] r_prod_odd;
    logic [CNT_W-1:0]         r_bin_even;
    logic [CNT_W-1:0]         r_bin_odd;
    logic                     r_odd_valid;
    logic                     r_final;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [ACC_W-1:0]  r_acc [NUM_BINS];
    logic                     r_out_valid;
    t_out_item                r_out_item;

    logic [CNT_W-1:0]         rd_idx;
    logic signed [ACC_W-1:0]  acc_rd;
    logic signed [PROD_W-1:0] addend;
    logic signed [ACC_W:0]    sum;
    logic signed [ACC_W-1:0]  sat_sum;
    logic                     out_free;
    logic                     cnt_last;

    assign rd_idx = i_cmd.add_odd ? r_bin_odd : (i_cmd.emit ? r_cnt : r_bin_even);
    assign acc_rd = r_acc[rd_idx];
    assign addend = i_cmd.add_odd ? r_prod_odd : r_prod_even;
    assign sum    = {acc_rd[ACC_W-1], acc_rd} + (ACC_W+1)'(addend);

    always_comb begin
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            sat_sum = sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            sat_sum = sum[ACC_W-1:0];
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign cnt_last = (r_cnt == CNT_W'(NUM_BINS - 1));

    assign o_status.odd_valid  = r_odd_valid;
    assign o_status.final_item = r_final;
    assign o_status.out_free   = out_free;
    assign o_status.emit_last  = cnt_last;

    // operands captured on the input transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prod_even <= i_in_item.query_even * i_in_item.step_even;
            r_prod_odd  <= i_in_item.query_odd * i_in_item.step_odd;
            r_bin_even  <= CNT_W'(i_in_item.code_byte[NIB_W-1:0]);
            r_bin_odd   <= CNT_W'(i_in_item.code_byte[CODE_W-1:NIB_W]);
            r_odd_valid <= i_in_item.odd_valid;
            r_final     <= i_in_item.final_item;
        end
    end

    // accumulators: add on even/odd steps, clear each bin as it is emitted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_BINS; k++) begin
                r_acc[k] <= '0;
            end
        end else if (i_cmd.add_even || i_cmd.add_odd) begin
            r_acc[rd_idx] <= sat_sum;
        end else if (i_cmd.emit) begin
            r_acc[rd_idx] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.emit) begin
            r_cnt <= cnt_last ? '0 : r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_item.bin_index <= BIN_W'(r_cnt);
            r_out_item.bin_sum   <= acc_rd;
            r_out_item.last_bin  <= cnt_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/code_binned_weighted_accumulator.sv =====
// top level: 16-bin code-indexed accumulator of query x step products
// an item is taken in idle, then added in the even step and, if its odd half is present, in the odd step
// the input stalls whenever the controller is not idle, so no new item is taken before the last is done
// on a final item the 16 bin sums follow, one per cycle while the output is not stalled
// one output register; the single accumulator read/write port sets the per-item cost
// synchronous active-low reset clears all bins to zero and returns the controller to idle
module code_binned_weighted_accumulator #(
    parameter int NUM_BINS = cbwa_pkg::NUM_BINS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cbwa_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cbwa_pkg::t_out_item o_out_item
);
    import cbwa_pkg::*;

    t_cmd    cmd;
    t_status status;

    cbwa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cbwa_datapath #(
        .NUM_BINS (NUM_BINS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== bench/code_binned_weighted_accumulator_tb.sv =====
// testbench for the code-binned weighted accumulator: queued stimulus, predictor and checker
`timescale 1ns / 100ps

module code_binned_weighted_accumulator_tb;

    import cbwa_pkg::*;

    localparam int          BINS        = NUM_BINS_DEF;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int          RAND_ITEMS  = 180;
    localparam int          HOLD_CYCLES = 300;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    // items waiting to be offered, with a flag to hold off until all sums are back
    t_in_item  code_items[$];
    bit        wait_for_drain[$];
    t_out_item bin_sums_due[$];

    logic signed [ACC_W-1:0] bin_totals[BINS];

    int unsigned cycles       = 0;
    int          mismatches   = 0;
    int          items_taken  = 0;
    int          sums_taken   = 0;
    int          hold_left    = 0;
    bit          hold_done    = 1'b0;
    bit          in_xfer      = 1'b0;

    code_binned_weighted_accumulator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic signed [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] acc,
                                                        logic signed [PROD_W-1:0] prod);
        longint s;
        s = longint'(acc) + longint'(prod);
        if (s > longint'(ACC_MAX)) s = longint'(ACC_MAX);
        if (s < longint'(ACC_MIN)) s = longint'(ACC_MIN);
        return s[ACC_W-1:0];
    endfunction

    // even product first, then odd, each saturating on its own
    task automatic fold_products(t_in_item it);
        logic signed [PROD_W-1:0] p_even;
        logic signed [PROD_W-1:0] p_odd;
        t_out_item                r;
        p_even = $signed(it.query_even) * $signed(it.step_even);
        p_odd  = $signed(it.query_odd) * $signed(it.step_odd);
        bin_totals[it.code_byte[3:0]] = sat_add(bin_totals[it.code_byte[3:0]], p_even);
        if (it.odd_valid)
            bin_totals[it.code_byte[7:4]] = sat_add(bin_totals[it.code_byte[7:4]], p_odd);
        if (it.final_item) begin
            for (int b = 0; b < BINS; b++) begin
                r.bin_index = BIN_W'(b);
                r.bin_sum   = bin_totals[b];
                r.last_bin  = (b == BINS - 1);
                bin_sums_due.insert(bin_sums_due.size(), r);
                bin_totals[b] = '0;
            end
        end
    endtask

    function automatic t_in_item make_item(logic [7:0] code, logic signed [15:0] qe,
                                           logic signed [15:0] se, logic signed [15:0] qo,
                                           logic signed [15:0] so, logic ov, logic fin);
        t_in_item it;
        it.code_byte  = code;
        it.query_even = qe;
        it.step_even  = se;
        it.query_odd  = qo;
        it.step_odd   = so;
        it.odd_valid  = ov;
        it.final_item = fin;
        return it;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_val();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    task automatic queue_item(t_in_item it, bit drain_first);
        code_items.insert(code_items.size(), it);
        wait_for_drain.insert(wait_for_drain.size(), drain_first);
    endtask

    // both transfers are taken here; outputs are registered so the order is safe
    always @(posedge i_clk) begin
        t_out_item want;
        bit        bad;
        in_xfer = 1'b0;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[code_binned_weighted_accumulator] ERROR");
            $finish;
        end else if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sums_taken++;
                if (bin_sums_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: bin %0d sum %0d last %0b",
                                 o_out_item.bin_index, o_out_item.bin_sum, o_out_item.last_bin);
                end else begin
                    want = bin_sums_due.pop_front();
                    bad  = (o_out_item.bin_index !== want.bin_index) ||
                           (o_out_item.bin_sum !== want.bin_sum) ||
                           (o_out_item.last_bin !== want.last_bin);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: want %0d/%0d/%0b, got %0d/%0d/%0b",
                                     want.bin_index, want.bin_sum, want.last_bin,
                                     o_out_item.bin_index, o_out_item.bin_sum,
                                     o_out_item.last_bin);
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                in_xfer = 1'b1;
                items_taken++;
                fold_products(i_in_item);
            end
        end
    end

    // sender: next item only once the current one has gone
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_xfer)) begin
            if (code_items.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (wait_for_drain[0] && bin_sums_due.size() != 0) begin
                i_in_valid <= 1'b0;
            end else if (!(items_taken >= 40 && items_taken < 100) &&
                         $urandom_range(0, 99) < 16) begin
                i_in_valid <= 1'b0;
            end else begin
                i_in_item  <= code_items.pop_front();
                void'(wait_for_drain.pop_front());
                i_in_valid <= 1'b1;
            end
        end
    end

    // receiver: random stalls, one long hold-off and a stretch with none
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && sums_taken >= 20) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (sums_taken >= 150 && sums_taken < 250) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < 16);
        end
    end

    initial begin
        t_in_item it;
        int       n_rand;
        int       vec_len;

        for (int b = 0; b < BINS; b++)
            bin_totals[b] = '0;

        // lone final item with nothing in it
        queue_item(make_item(8'h00, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 1'b1), 0);
        // field extremes, top and bottom bins
        queue_item(make_item(8'hF0, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0), 0);
        queue_item(make_item(8'h0F, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b1, 1'b0), 0);
        // odd half absent: its fields and high nibble must be ignored
        queue_item(make_item(8'hA5, 16'sh0001, 16'shFFFF, 16'shFFFF, 16'shFFFF, 1'b0, 1'b0), 0);
        // both halves on one bin, final
        queue_item(make_item(8'h33, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh0001, 1'b1, 1'b1), 0);
        // final item with odd half absent and junk in its fields
        queue_item(make_item(8'hFF, 16'shFFFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b1), 0);
        queue_item(make_item(8'h96, 16'sh1234, 16'shEDCB, 16'sh5A5A, 16'shA5A5, 1'b1, 1'b1), 0);

        // the first random item waits until every sum so far has come back
        n_rand = 0;
        while (n_rand < RAND_ITEMS) begin
            vec_len = $urandom_range(1, 12);
            for (int k = 0; k < vec_len; k++) begin
                it = make_item(8'($urandom), pick_val(), pick_val(), pick_val(), pick_val(),
                               ($urandom_range(0, 4) != 0), (k == vec_len - 1));
                queue_item(it, n_rand == 0);
                n_rand++;
            end
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (code_items.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (bin_sums_due.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && bin_sums_due.size() == 0) begin
            $display("[code_binned_weighted_accumulator] OK");
        end else begin
            $display("[code_binned_weighted_accumulator] ERROR");
        end
        $finish;
    end

endmodule
